[rtl/frgb_pkg.sv]
`default_nettype none
package frgb_pkg;

   typedef struct packed {
      logic [31:0] red_bits;
      logic [31:0] green_bits;
      logic [31:0] blue_bits;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] sample_first;
      logic [31:0] sample_second;
      logic [31:0] sample_third;
      logic        line_end;
      logic        frame_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      MODE_BAYER = 2'd0,
      MODE_RGB16 = 2'd1,
      MODE_FLOAT = 2'd2,
      MODE_ZERO  = 2'd3
   } mode_type;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MODE   = 2'd2;

   // Work item handed from the front part to the back part.
   typedef struct packed {
      mode_type    mode;
      logic [31:0] ch0;
      logic [31:0] ch1;
      logic [31:0] ch2;
      logic        line_end;
      logic        frame_end;
   } work_type;

   // Truncated value of clamp(x,0,1)*65535 in single precision.
   // For 0<=x<1 with exponent e (biased), x = m*2^(e-150), m 24-bit.
   // The float product rounds to nearest even at 24 bits before truncation.
   function automatic logic [15:0] to_u16(input logic [31:0] f);
      logic [7:0]  e;
      logic [23:0] m;
      logic [39:0] prod;
      logic [47:0] sh;
      logic [7:0]  nsh;
      logic [47:0] full;
      logic [5:0]  lead;
      logic [47:0] rnd;
      logic [47:0] keep;
      logic [47:0] half;
      logic [47:0] lsb;
      logic [47:0] mask;
      logic [47:0] rem;
      logic [47:0] q;
      logic [15:0] r;
      e    = f[30:23];
      m    = {(e != 8'd0), f[22:0]};
      prod = m * 40'd65535;
      full = {8'd0, prod};
      lead = 6'd0;
      for (int i = 0; i < 40; i++) begin
         if (full[i]) lead = 6'(i);
      end
      if (lead > 6'd23) begin
         keep = 48'd1 << (lead - 6'd23);
      end else begin
         keep = 48'd1;
      end
      lsb  = keep;
      half = keep >> 1;
      mask = keep - 48'd1;
      rem  = full & mask;
      q    = full & ~mask;
      if (rem > half || (rem == half && half != 48'd0 && (full & lsb) != 48'd0)) begin
         q = q + lsb;
      end
      nsh = 8'd150 - ((e == 8'd0) ? 8'd1 : e);
      if (nsh > 8'd47) begin
         sh = 48'd0;
      end else begin
         sh = q >> nsh[5:0];
      end
      rnd = sh;
      // NaN of either sign saturates high, so it is tested before the sign.
      if (f[30:23] == 8'hFF && f[22:0] != 23'd0) begin
         r = 16'hFFFF;
      end else if (f[31]) begin
         r = 16'd0;
      end else if (f[30:23] >= 8'd127) begin
         r = 16'hFFFF;
      end else if (rnd >= 48'd65535) begin
         r = 16'hFFFF;
      end else begin
         r = rnd[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/frgb_front.sv]
`default_nettype none
module frgb_front #(
   parameter int MAX_DIMENSION = 8192
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  frgb_pkg::req_payload_type  req_payload,
   input  wire [13:0]                 image_width,
   input  wire [13:0]                 image_height,
   input  frgb_pkg::mode_type         mode,
   output logic                       work_valid,
   input  wire                        work_stall,
   output frgb_pkg::work_type         work
);
   localparam int CW = $clog2(MAX_DIMENSION) + 1;

   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] w_eff, h_eff;
   logic          le, fe, odd_row, odd_col, take;
   logic [31:0]   pick;

   always_comb begin
      if (image_width == 14'd0) w_eff = CW'(1);
      else if (32'(image_width) > MAX_DIMENSION) w_eff = CW'(MAX_DIMENSION);
      else w_eff = CW'(image_width);
      if (image_height == 14'd0) h_eff = CW'(1);
      else if (32'(image_height) > MAX_DIMENSION) h_eff = CW'(MAX_DIMENSION);
      else h_eff = CW'(image_height);
   end

   assign req_stall = work_stall;
   assign take = req_valid && !work_stall;
   assign le = (col_ff + CW'(1)) >= w_eff;
   assign fe = le && ((row_ff + CW'(1)) >= h_eff);
   assign odd_row = row_ff[0];
   assign odd_col = col_ff[0];

   always_comb begin
      if (!odd_row) pick = odd_col ? req_payload.green_bits : req_payload.red_bits;
      else pick = odd_col ? req_payload.blue_bits : req_payload.green_bits;
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if (le) begin
            col_in = '0;
            row_in = fe ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      work.mode      = mode;
      work.ch0       = (mode == frgb_pkg::MODE_BAYER) ? pick : req_payload.red_bits;
      work.ch1       = req_payload.green_bits;
      work.ch2       = req_payload.blue_bits;
      work.line_end  = le;
      work.frame_end = fe;
   end

   assign work_valid = req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < CW'(MAX_DIMENSION)) else $error("column out of range");
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      take && le |=> col_ff == '0) else $error("column did not wrap");
   a_frame: assert property (@(posedge clock) disable iff (reset)
      take && fe |=> row_ff == '0) else $error("row did not wrap");
endmodule
`default_nettype wire

[rtl/frgb_back.sv]
`default_nettype none
module frgb_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        work_valid,
   output logic                       work_stall,
   input  frgb_pkg::work_type         work,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output frgb_pkg::rsp_payload_type  rsp_payload
);
   // Two-entry queue of work items, then one output register.
   frgb_pkg::work_type q_ff [2];
   logic               q0_in_sel;
   logic [1:0]         cnt_ff, cnt_in;
   logic               rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic               push, pop, out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   frgb_pkg::rsp_payload_type out_ff, out_in;
   frgb_pkg::work_type head;

   assign head       = q_ff[rd_ptr_ff];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pop        = (cnt_ff != 2'd0) && out_free;
   assign work_stall = (cnt_ff == 2'd2);
   assign push       = work_valid && !work_stall;
   assign q0_in_sel  = wr_ptr_ff;

   always_comb begin
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      rsp_valid_in = pop ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      out_in = out_ff;
      if (pop) begin
         out_in.line_end  = head.line_end;
         out_in.frame_end = head.frame_end;
         case (head.mode)
            frgb_pkg::MODE_BAYER: begin
               out_in.sample_first  = {16'd0, frgb_pkg::to_u16(head.ch0)};
               out_in.sample_second = '0;
               out_in.sample_third  = '0;
            end
            frgb_pkg::MODE_RGB16: begin
               out_in.sample_first  = {16'd0, frgb_pkg::to_u16(head.ch0)};
               out_in.sample_second = {16'd0, frgb_pkg::to_u16(head.ch1)};
               out_in.sample_third  = {16'd0, frgb_pkg::to_u16(head.ch2)};
            end
            frgb_pkg::MODE_FLOAT: begin
               out_in.sample_first  = head.ch0;
               out_in.sample_second = head.ch1;
               out_in.sample_third  = head.ch2;
            end
            default: begin
               out_in.sample_first  = '0;
               out_in.sample_second = '0;
               out_in.sample_third  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[q0_in_sel] <= work;
      out_ff <= out_in;
      if (reset) begin
         cnt_ff       <= '0;
         rd_ptr_ff    <= 1'b0;
         wr_ptr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = out_ff;

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> rd_ptr_ff == wr_ptr_ff)
      else $error("queue pointers disagree with count");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff) else $error("popped item not presented");
endmodule
`default_nettype wire

[rtl/float_rgb_to_bayer_rggb.sv]
// An accepted pixel is written into a two-entry queue, moves on from there
// into the output register and is presented on rsp; rsp_stall can hold it.
// Throughput: one pixel per cycle unless the queue is full; the queue and
// output register decouple the counter front end from the conversion back end.
// Reset (synchronous, active high) sets width and height to 1, mode to Bayer,
// clears the line and frame counters and empties the queue.
`default_nettype none
module float_rgb_to_bayer_rggb #(
   parameter int MAX_DIMENSION = 8192
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  frgb_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output frgb_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_psel,
   input  wire                        csr_penable,
   input  wire                        csr_pwrite,
   input  wire [3:0]                  csr_paddr,
   input  wire [31:0]                 csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   logic [13:0]        width_ff, height_ff;
   frgb_pkg::mode_type mode_ff;
   logic               wr;
   logic               work_valid, work_stall;
   frgb_pkg::work_type work;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 14'd1;
         height_ff <= 14'd1;
         mode_ff   <= frgb_pkg::MODE_BAYER;
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[3:2] == frgb_pkg::REG_WIDTH)  width_ff  <= csr_pwdata[13:0];
         if (csr_paddr[3:2] == frgb_pkg::REG_HEIGHT) height_ff <= csr_pwdata[13:0];
         if (csr_paddr[3:2] == frgb_pkg::REG_MODE)
            mode_ff <= frgb_pkg::mode_type'(csr_pwdata[1:0]);
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         frgb_pkg::REG_WIDTH:  csr_prdata = {18'd0, width_ff};
         frgb_pkg::REG_HEIGHT: csr_prdata = {18'd0, height_ff};
         frgb_pkg::REG_MODE:   csr_prdata = {30'd0, mode_ff};
         default:              csr_prdata = '0;
      endcase
   end

   frgb_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .image_width(width_ff), .image_height(height_ff), .mode(mode_ff),
      .work_valid(work_valid), .work_stall(work_stall), .work(work)
   );

   frgb_back u_back (
      .clock(clock), .reset(reset),
      .work_valid(work_valid), .work_stall(work_stall), .work(work),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );
endmodule
`default_nettype wire

[sim/frgb_checker.sv]
`default_nettype none
module frgb_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire                        req_stall,
   input  frgb_pkg::req_payload_type  req_payload,
   input  wire                        rsp_valid,
   input  wire                        rsp_stall,
   input  frgb_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_psel,
   input  wire                        csr_penable,
   input  wire                        csr_pwrite,
   input  wire [3:0]                  csr_paddr,
   input  wire [31:0]                 csr_pwdata,
   input  wire                        csr_pready,
   output int                         fail_count,
   output int                         pending_count
);

   localparam int MAX_DIM = 8192;

   logic [13:0]               width_reg;
   logic [13:0]               height_reg;
   logic [1:0]                mode_reg;
   int                        column_pos;
   int                        row_pos;
   frgb_pkg::rsp_payload_type pixel_queue[$];
   frgb_pkg::rsp_payload_type want;
   frgb_pkg::rsp_payload_type got;

   // Clamp to [0,1], scale by 65535 with single-precision rounding, truncate.
   function automatic logic [31:0] scale_channel(input logic [31:0] f);
      logic [39:0] prod;
      logic [39:0] q;
      logic [39:0] rem;
      logic [39:0] half;
      int          len;
      int          drop;
      int          shift;
      if (f[30:23] == 8'hFF && f[22:0] != 23'd0) return 32'd65535;
      if (f[31]) return 32'd0;
      if (f[30:23] >= 8'd127) return 32'd65535;
      if (f[30:23] == 8'd0) return 32'd0;
      prod = {1'b1, f[22:0]} * 40'd65535;
      len = 0;
      for (int i = 0; i < 40; i++) if (prod[i]) len = i + 1;
      drop = (len > 24) ? len - 24 : 0;
      q = prod >> drop;
      if (drop > 0) begin
         rem  = prod & ((40'd1 << drop) - 40'd1);
         half = 40'd1 << (drop - 1);
         if (rem > half || (rem == half && q[0])) q = q + 40'd1;
      end
      shift = 150 - int'(f[30:23]) - drop;
      if (shift >= 40) return 32'd0;
      if (shift > 0) q = q >> shift;
      else q = q << (-shift);
      if (q >= 40'd65535) return 32'd65535;
      return {16'd0, q[15:0]};
   endfunction

   function automatic int clip_dim(input logic [13:0] d);
      if (d == 14'd0) return 1;
      if (int'(d) > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   task automatic report(input string field, input logic [31:0] e, input logic [31:0] a);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %h, got %h at %0t", field, e, a, $realtime);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = 14'd1;
         height_reg = 14'd1;
         mode_reg   = frgb_pkg::MODE_BAYER;
         column_pos = 0;
         row_pos    = 0;
         pixel_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (pixel_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result transfer %h at %0t", got, $realtime);
            end else begin
               want = pixel_queue.pop_front();
               if (got.sample_first !== want.sample_first)
                  report("sample_first", want.sample_first, got.sample_first);
               if (got.sample_second !== want.sample_second)
                  report("sample_second", want.sample_second, got.sample_second);
               if (got.sample_third !== want.sample_third)
                  report("sample_third", want.sample_third, got.sample_third);
               if (got.line_end !== want.line_end)
                  report("line_end", want.line_end, got.line_end);
               if (got.frame_end !== want.frame_end)
                  report("frame_end", want.frame_end, got.frame_end);
            end
         end
         if (req_valid && !req_stall) begin
            want = '0;
            case (frgb_pkg::mode_type'(mode_reg))
               frgb_pkg::MODE_BAYER: begin
                  if (row_pos[0] == 1'b0)
                     want.sample_first = column_pos[0] ? scale_channel(req_payload.green_bits)
                                                       : scale_channel(req_payload.red_bits);
                  else
                     want.sample_first = column_pos[0] ? scale_channel(req_payload.blue_bits)
                                                       : scale_channel(req_payload.green_bits);
               end
               frgb_pkg::MODE_RGB16: begin
                  want.sample_first  = scale_channel(req_payload.red_bits);
                  want.sample_second = scale_channel(req_payload.green_bits);
                  want.sample_third  = scale_channel(req_payload.blue_bits);
               end
               frgb_pkg::MODE_FLOAT: begin
                  want.sample_first  = req_payload.red_bits;
                  want.sample_second = req_payload.green_bits;
                  want.sample_third  = req_payload.blue_bits;
               end
               default: ;
            endcase
            // A counter at or past a shrunken limit closes its line or frame at once.
            want.line_end = (column_pos + 1 >= clip_dim(width_reg));
            if (want.line_end) begin
               column_pos = 0;
               want.frame_end = (row_pos + 1 >= clip_dim(height_reg));
               row_pos = want.frame_end ? 0 : row_pos + 1;
            end else begin
               column_pos++;
            end
            pixel_queue.push_back(want);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               frgb_pkg::REG_WIDTH:  width_reg  = csr_pwdata[13:0];
               frgb_pkg::REG_HEIGHT: height_reg = csr_pwdata[13:0];
               frgb_pkg::REG_MODE:   mode_reg   = csr_pwdata[1:0];
               default: ;
            endcase
         end
      end
      pending_count = pixel_queue.size();
   end

   initial fail_count = 0;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none
module tb_top;

   localparam logic [3:0] UNUSED_ADDR = 4'd12;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   frgb_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   frgb_pkg::rsp_payload_type rsp_payload;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [3:0]                csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;
   int                        fail_count;
   int                        pending_count;
   bit                        long_hold;

   float_rgb_to_bayer_rggb dut (.*);

   frgb_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side back-pressure: mostly short, sometimes long, plus one long hold.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         n = $urandom_range(0, 99);
         if (n < 60) rsp_stall <= 1'b0;
         else if (n < 97) rsp_stall <= 1'b1;
         else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] w, input logic [31:0] h, input logic [31:0] m);
      csr_write({frgb_pkg::REG_WIDTH, 2'b00}, w);
      csr_write({frgb_pkg::REG_HEIGHT, 2'b00}, h);
      csr_write({frgb_pkg::REG_MODE, 2'b00}, m);
      csr_write(UNUSED_ADDR, $urandom);
   endtask

   // Waits for the transfer of the item currently offered, then maybe idles.
   task automatic send_pixel(input frgb_pkg::req_payload_type p, input bit allow_gap);
      bit taken;
      int n;
      req_valid   <= 1'b1;
      req_payload <= p;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      n = $urandom_range(0, 99);
      if (allow_gap && n >= 60) begin
         req_valid <= 1'b0;
         repeat ((n < 97) ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_channel();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h3F80_0000;
         3: return 32'h3F7F_FFFF;
         4: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
         5: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
         6: return {1'b1, 31'($urandom)};
         7: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 1) ? $urandom : 0)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd2;
         3: return 32'd8192;
         4: return 32'd16383;
         5: return 32'd8193;
         default: return $urandom_range(3, 9);
      endcase
   endfunction

   localparam logic [31:0] SPECIALS [12] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F7F_FFFF,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0001,
      32'h0000_0001, 32'hBF00_0000, 32'h3F00_0000, 32'h4100_0000};

   initial begin
      frgb_pkg::req_payload_type p;
      int phase_items;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      long_hold   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings first, then every special value in RGB16 mode, then Bayer, float and zero modes.
      for (int i = 0; i < 3; i++) send_pixel('{SPECIALS[i], SPECIALS[i + 1], SPECIALS[i + 2]}, 1);
      drain();
      configure(3, 2, frgb_pkg::MODE_RGB16);
      for (int i = 0; i < 12; i++)
         send_pixel('{SPECIALS[i], SPECIALS[(i + 4) % 12], SPECIALS[(i + 8) % 12]}, 1);
      drain();
      configure(2, 2, frgb_pkg::MODE_BAYER);
      for (int i = 0; i < 4; i++) send_pixel('{32'h3F00_0000, 32'h3E80_0000, 32'h3F40_0000}, 0);
      drain();
      configure(0, 16383, frgb_pkg::MODE_FLOAT);
      for (int i = 0; i < 3; i++) send_pixel('{$urandom, $urandom, $urandom}, 1);
      drain();
      configure(8192, 8192, frgb_pkg::MODE_ZERO);
      for (int i = 0; i < 3; i++) send_pixel('{$urandom, $urandom, $urandom}, 1);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         configure(pick_dim(), pick_dim(), $urandom_range(0, 3));
         phase_items = 160;
         for (int i = 0; i < phase_items; i++) begin
            if (phase == 3 && i == 10) long_hold = 1'b1;
            p = '{pick_channel(), pick_channel(), pick_channel()};
            send_pixel(p, 1);
         end
         drain();
      end

      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
